### hdl/dks_pkg.sv
// Shared types, constants and bit-selection functions for the DES key schedule.
// Depends on nothing; used by every module under hdl/ except dks_checker.
package dks_pkg;

    localparam int KEY_W    = 64;
    localparam int HALF_W   = 28;
    localparam int CD_W     = 56;
    localparam int SUBKEY_W = 48;
    localparam int ROUND_W  = 4;
    localparam int PC1_N    = 56;
    localparam int PC2_N    = 48;

    localparam logic [ROUND_W-1:0] ROUND_FIRST = 4'd0;
    localparam logic [ROUND_W-1:0] ROUND_LAST  = 4'd15;

    typedef logic [HALF_W-1:0]   half_t;
    typedef logic [ROUND_W-1:0]  round_t;
    typedef logic [SUBKEY_W-1:0] subkey_t;

    // C and D halves as they leave PC-1
    typedef struct packed {
        half_t c;
        half_t d;
    } cd_t;

    // One subkey transfer on the result side
    typedef struct packed {
        round_t  round;
        subkey_t subkey;
        logic    last;
    } result_t;

    // Fill status of a queue
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Bit positions, 1 = MSB of the source word
    localparam byte unsigned PC1_TAB [PC1_N] = '{
        57, 49, 41, 33, 25, 17,  9,  1, 58, 50, 42, 34, 26, 18,
        10,  2, 59, 51, 43, 35, 27, 19, 11,  3, 60, 52, 44, 36,
        63, 55, 47, 39, 31, 23, 15,  7, 62, 54, 46, 38, 30, 22,
        14,  6, 61, 53, 45, 37, 29, 21, 13,  5, 28, 20, 12,  4
    };

    localparam byte unsigned PC2_TAB [PC2_N] = '{
        14, 17, 11, 24,  1,  5,  3, 28, 15,  6, 21, 10,
        23, 19, 12,  4, 26,  8, 16,  7, 27, 20, 13,  2,
        41, 52, 31, 37, 47, 55, 30, 40, 51, 45, 33, 48,
        44, 49, 39, 56, 34, 53, 46, 42, 50, 36, 29, 32
    };

    function automatic cd_t pc1(input logic [KEY_W-1:0] key);
        logic [CD_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < PC1_N; i++) begin
            acc[PC1_N-1-i] = key[KEY_W-int'(PC1_TAB[i])];
        end
        return cd_t'(acc);
    endfunction

    function automatic subkey_t pc2(input logic [CD_W-1:0] cd);
        subkey_t acc;
        acc = '0;
        for (int i = 0; i < PC2_N; i++) begin
            acc[PC2_N-1-i] = cd[CD_W-int'(PC2_TAB[i])];
        end
        return acc;
    endfunction

    // Rounds 0, 1, 8 and 15 shift by one, all others by two
    function automatic logic shift_two(input round_t r);
        return !(r inside {4'd0, 4'd1, 4'd8, 4'd15});
    endfunction

    function automatic half_t rotate_half(input half_t h, input logic two);
        return two ? {h[HALF_W-3:0], h[HALF_W-1:HALF_W-2]}
                   : {h[HALF_W-2:0], h[HALF_W-1]};
    endfunction

endpackage

### hdl/dks_fifo.sv
// Small first-in first-out queue of generic width and depth, flop based.
// Depends on dks_pkg (q_status_t).
module dks_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output dks_pkg::q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign do_wr   = wr_en && !status.full;
    assign do_rd   = rd_en && !status.empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### hdl/dks_front.sv
// Key intake: registers PC-1 of each accepted key and hands C/D to the queue.
// Depends on dks_pkg (pc1, cd_t).
module dks_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic [dks_pkg::KEY_W-1:0]     key,
    output logic                          full,
    output logic                          cd_valid,
    output dks_pkg::cd_t                  cd,
    input  logic                          cd_full
);

    logic         valid_reg, valid_next;
    dks_pkg::cd_t cd_reg;
    logic         take, hand_off;

    assign hand_off = valid_reg && !cd_full;
    assign full     = valid_reg && cd_full;
    assign take     = push && !full;
    assign cd_valid = valid_reg;
    assign cd       = cd_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (hand_off)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cd_reg <= dks_pkg::pc1(key);
        end
    end

endmodule

### hdl/dks_back.sv
// Round sequencer: rotates C/D once per round and forms each subkey via PC-2.
// Depends on dks_pkg (pc2, shift_two, rotate_half, cd_t, result_t).
module dks_back (
    input  logic               clk,
    input  logic               rst_n,
    input  dks_pkg::cd_t       cd,
    input  dks_pkg::q_status_t cd_status,
    output logic               cd_pop,
    output logic               res_push,
    output dks_pkg::result_t   res,
    input  dks_pkg::q_status_t res_status
);

    logic            busy_reg, busy_next;
    dks_pkg::round_t round_reg, round_next;
    dks_pkg::half_t  c_reg, c_next, d_reg, d_next;
    dks_pkg::half_t  c_rot, d_rot;
    logic            two, emit, done, load;

    assign two   = dks_pkg::shift_two(round_reg);
    assign c_rot = dks_pkg::rotate_half(c_reg, two);
    assign d_rot = dks_pkg::rotate_half(d_reg, two);

    assign emit   = busy_reg && !res_status.full;
    assign done   = emit && (round_reg == dks_pkg::ROUND_LAST);
    assign load   = !cd_status.empty && (!busy_reg || done);
    assign cd_pop = load;

    assign res_push   = emit;
    assign res.round  = round_reg;
    assign res.subkey = dks_pkg::pc2({c_rot, d_rot});
    assign res.last   = (round_reg == dks_pkg::ROUND_LAST);

    always_comb
    begin
        busy_next  = busy_reg;
        round_next = round_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        if (emit)
        begin
            c_next     = c_rot;
            d_next     = d_rot;
            round_next = round_reg + 1'b1;
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
        if (load)
        begin
            busy_next  = 1'b1;
            round_next = dks_pkg::ROUND_FIRST;
            c_next     = cd.c;
            d_next     = cd.d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            round_reg <= dks_pkg::ROUND_FIRST;
        end
        else
        begin
            busy_reg  <= busy_next;
            round_reg <= round_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg <= c_next;
        d_reg <= d_next;
    end

endmodule

### hdl/des_key_schedule_top.sv
// Top level of the DES key schedule: intake, C/D queue, round sequencer, result queue.
// Depends on dks_pkg, dks_front, dks_fifo, dks_back.
//
//  Channel   Dir   Handshake           Payload
//  -------   ---   -----------------   ---------------------------------------
//  key       in    push / full         key[63:0]  (bit 1 = MSB, parity unused)
//  subkey    out   empty / pop         round[3:0], subkey[47:0], last
//
//  Timing: one key yields sixteen subkey transfers, one per cycle while the
//  result queue is not full; a new key is loaded in the same cycle as the
//  previous key's last round goes out, so the single rotate/PC-2 round unit
//  sets the key rate. From key transfer to first subkey on the ports, data
//  passes the PC-1 register, C/D queue, sequencer C/D registers and result queue.
//  Reset clears all control state; no clearing pass is needed.
//  A stalled result side fills the result queue, then holds the sequencer,
//  then the C/D queue and intake, and finally raises full.
module des_key_schedule_top #(
    parameter int CD_DEPTH  = 2,
    parameter int OUT_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [63:0] key,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  round,
    output logic [47:0] subkey,
    output logic        last
);

    localparam int CD_BITS  = $bits(dks_pkg::cd_t);
    localparam int RES_BITS = $bits(dks_pkg::result_t);

    // intake -> C/D queue
    logic               front_valid;
    dks_pkg::cd_t       front_cd;
    dks_pkg::q_status_t cd_status;

    // C/D queue -> sequencer
    logic [CD_BITS-1:0] cd_rd_bits;
    logic               cd_pop;

    // sequencer -> result queue
    logic               res_push;
    dks_pkg::result_t   res_wr;
    dks_pkg::q_status_t res_status;
    logic [RES_BITS-1:0] res_rd_bits;
    dks_pkg::result_t   res_rd;

    dks_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .key      (key),
        .full     (full),
        .cd_valid (front_valid),
        .cd       (front_cd),
        .cd_full  (cd_status.full)
    );

    // Decouples intake from the sixteen-round sequence
    dks_fifo #(
        .WIDTH (CD_BITS),
        .DEPTH (CD_DEPTH)
    ) u_cd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_valid),
        .wr_data (front_cd),
        .rd_en   (cd_pop),
        .rd_data (cd_rd_bits),
        .status  (cd_status)
    );

    dks_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cd         (dks_pkg::cd_t'(cd_rd_bits)),
        .cd_status  (cd_status),
        .cd_pop     (cd_pop),
        .res_push   (res_push),
        .res        (res_wr),
        .res_status (res_status)
    );

    // Result queue keeps the sequencer running while the consumer stalls
    dks_fifo #(
        .WIDTH (RES_BITS),
        .DEPTH (OUT_DEPTH)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_wr),
        .rd_en   (pop),
        .rd_data (res_rd_bits),
        .status  (res_status)
    );

    assign res_rd = dks_pkg::result_t'(res_rd_bits);
    assign empty  = res_status.empty;
    assign round  = res_rd.round;
    assign subkey = res_rd.subkey;
    assign last   = res_rd.last;

endmodule

### hdl/dks_checker.sv
// Port-level checks on the DES key schedule result stream, bound to the top level.
// Depends on des_key_schedule_top port names only.
module dks_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [3:0]  round,
    input logic [47:0] subkey,
    input logic        last
);

    // last marks the sixteenth round and nothing else
    a_last_round: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (last == (round == 4'd15)))
        else $error("last flag does not match round 15");

    // rounds of one key follow each other in order
    a_round_step: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last) |=> (!empty && (round == $past(round) + 4'd1)))
        else $error("round sequence broken inside a key");

    // a waiting result holds while not taken
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(round) && $stable(subkey)))
        else $error("result changed while stalled");

    // a new key always starts at round 0
    a_first_round: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && last) ##1 !empty |-> (round == 4'd0))
        else $error("key did not start at round 0");

endmodule

bind des_key_schedule_top dks_checker u_dks_checker (.*);

### dv/dks_subkey_checker.sv
`timescale 1ns / 1ps
// Checker for the DES key schedule. It watches the key and subkey queue ports,
// predicts the sixteen round subkeys of every key and compares them in order.
// Depends on dks_pkg for the round, subkey and result types.
module dks_subkey_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [63:0] key,
    input  logic        empty,
    input  logic        pop,
    input  logic [3:0]  round,
    input  logic [47:0] subkey,
    input  logic        last,
    output int          errors,
    output int          pending,
    output int          keys_in,
    output int          subkeys_out
);

    localparam int MAX_REPORTS = 40;

    // Key bit positions picked by PC-1, 1 = MSB of the 64-bit key
    localparam int PC1_SEL [56] = '{
        57, 49, 41, 33, 25, 17,  9,  1, 58, 50, 42, 34, 26, 18,
        10,  2, 59, 51, 43, 35, 27, 19, 11,  3, 60, 52, 44, 36,
        63, 55, 47, 39, 31, 23, 15,  7, 62, 54, 46, 38, 30, 22,
        14,  6, 61, 53, 45, 37, 29, 21, 13,  5, 28, 20, 12,  4
    };

    // C:D bit positions picked by PC-2, 1 = MSB of the 56-bit word
    localparam int PC2_SEL [48] = '{
        14, 17, 11, 24,  1,  5,  3, 28, 15,  6, 21, 10,
        23, 19, 12,  4, 26,  8, 16,  7, 27, 20, 13,  2,
        41, 52, 31, 37, 47, 55, 30, 40, 51, 45, 33, 48,
        44, 49, 39, 56, 34, 53, 46, 42, 50, 36, 29, 32
    };

    localparam int ROT_AMT [16] = '{1, 1, 2, 2, 2, 2, 2, 2, 1, 2, 2, 2, 2, 2, 2, 1};

    dks_pkg::result_t expected_subkeys [$];
    dks_pkg::result_t want;
    int      err_cnt;
    int      key_cnt;
    int      sub_cnt;

    assign errors      = err_cnt;
    assign pending     = expected_subkeys.size();
    assign keys_in     = key_cnt;
    assign subkeys_out = sub_cnt;

    // Queue up the sixteen subkeys of one key in round order
    function automatic void derive_subkeys(input logic [63:0] k);
        logic [55:0] cd;
        logic [27:0] c;
        logic [27:0] d;
        logic [55:0] joined;
        logic [47:0] sk;
        dks_pkg::result_t item;
        for (int i = 0; i < 56; i++)
        begin
            cd[55-i] = k[64-PC1_SEL[i]];
        end
        c = cd[55:28];
        d = cd[27:0];
        for (int r = 0; r < 16; r++)
        begin
            for (int s = 0; s < ROT_AMT[r]; s++)
            begin
                c = {c[26:0], c[27]};
                d = {d[26:0], d[27]};
            end
            joined = {c, d};
            for (int i = 0; i < 48; i++)
            begin
                sk[47-i] = joined[56-PC2_SEL[i]];
            end
            item.round  = dks_pkg::round_t'(r);
            item.subkey = sk;
            item.last   = (r == 15);
            expected_subkeys.push_back(item);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_subkeys.delete();
            err_cnt = 0;
            key_cnt = 0;
            sub_cnt = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                sub_cnt++;
                if (expected_subkeys.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t: unexpected subkey transfer: round %0d subkey %h last %b",
                                 $time, round, subkey, last);
                end
                else
                begin
                    want = expected_subkeys.pop_front();
                    if (round !== want.round)
                    begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS)
                            $display("%0t: round mismatch: expected %0d, actual %0d",
                                     $time, want.round, round);
                    end
                    if (subkey !== want.subkey)
                    begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS)
                            $display("%0t: subkey mismatch (round %0d): expected %h, actual %h",
                                     $time, want.round, want.subkey, subkey);
                    end
                    if (last !== want.last)
                    begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS)
                            $display("%0t: last mismatch (round %0d): expected %b, actual %b",
                                     $time, want.round, want.last, last);
                    end
                end
            end
            if (push && !full)
            begin
                key_cnt++;
                derive_subkeys(key);
            end
        end
    end

endmodule

### dv/tb_des_key_schedule_top.sv
`timescale 1ns / 1ps
// Testbench top for des_key_schedule_top: clock, reset, key stimulus, pop pattern, verdict.
// Depends on dks_pkg, the block under hdl/ and dks_subkey_checker.
module tb_des_key_schedule_top;

    // Slowest legal run: each key waits out the longest pop stalls for its
    // subkeys plus the longest sender gap; about 430 keys, taken four times over.
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int N_RANDOM    = 410;
    localparam int DRAIN_WAIT  = 12;   // keep some margin after the last subkey

    localparam logic [63:0] PARITY_MASK = 64'h0101_0101_0101_0101;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [63:0] key;
    logic        empty;
    logic        pop;
    logic [3:0]  round;
    logic [47:0] subkey;
    logic        last;

    int errors;
    int pending;
    int keys_in;
    int subkeys_out;
    int cycle_count = 0;
    int n_directed;

    logic [63:0] key_list [$];

    des_key_schedule_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .key    (key),
        .empty  (empty),
        .pop    (pop),
        .round  (round),
        .subkey (subkey),
        .last   (last)
    );

    // Predicts and compares; only the failure and progress counts come back.
    dks_subkey_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .key         (key),
        .empty       (empty),
        .pop         (pop),
        .round       (round),
        .subkey      (subkey),
        .last        (last),
        .errors      (errors),
        .pending     (pending),
        .keys_in     (keys_in),
        .subkeys_out (subkeys_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: a hung handshake or missing subkeys end the run here.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout after %0d cycles, %0d subkeys still expected",
                 $time, cycle_count, pending);
        $display("TB_ERROR");
        $finish;
    end

    // Directed keys: extremes, weak and semi-weak keys, parity-only changes,
    // single bits on both data and parity positions.
    task automatic build_directed();
        key_list.push_back(64'h0000_0000_0000_0000);
        key_list.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        key_list.push_back(PARITY_MASK);                  // weak key, parity bits only
        key_list.push_back(~PARITY_MASK);                 // all data bits, no parity
        key_list.push_back(64'hFEFE_FEFE_FEFE_FEFE);
        key_list.push_back(64'hE0E0_E0E0_F1F1_F1F1);      // weak
        key_list.push_back(64'h1F1F_1F1F_0E0E_0E0E);      // weak
        key_list.push_back(64'h01FE_01FE_01FE_01FE);      // semi-weak pair
        key_list.push_back(64'hFE01_FE01_FE01_FE01);
        key_list.push_back(64'h133457799BBCDFF1);
        key_list.push_back(64'h133457799BBCDFF1 ^ PARITY_MASK);  // same subkeys expected
        key_list.push_back(64'h8000_0000_0000_0000);
        key_list.push_back(64'h0000_0000_0000_0001);      // parity bit only
        key_list.push_back(64'h0000_0000_0000_0002);
        key_list.push_back(64'hAAAA_AAAA_AAAA_AAAA);
        key_list.push_back(64'h5555_5555_5555_5555);
        key_list.push_back(64'h0F0F_0F0F_F0F0_F0F0);
        key_list.push_back(64'h0123_4567_89AB_CDEF);
    endtask

    // Random keys: mostly uniform, some parity-only variants of the previous
    // key, some sparse keys and some byte-repeated patterns.
    task automatic build_random();
        logic [63:0] k;
        logic [7:0]  b;
        int          sel;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 60)
                k = {$urandom, $urandom};
            else if (sel < 75)
                k = key_list[key_list.size()-1] ^ ({$urandom, $urandom} & PARITY_MASK);
            else if (sel < 88)
                k = (64'd1 << $urandom_range(0, 63)) | (64'd1 << $urandom_range(0, 63));
            else
            begin
                b = 8'($urandom_range(0, 255));
                k = {8{b}};
            end
            key_list.push_back(k);
        end
    endtask

    // Result side: pop pattern changes every stretch of cycles. Modes are
    // always ready, coin flip, sparse, and long stalls.
    initial
    begin : receiver
        int mode;
        int stretch;
        int stall;
        @(posedge rst_n);
        forever
        begin
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(20, 200);
            stall   = 0;
            repeat (stretch)
            begin
                @(negedge clk);
                case (mode)
                    0: pop <= 1'b1;
                    1: pop <= 1'($urandom_range(0, 1));
                    2: pop <= ($urandom_range(0, 3) == 0);
                    default:
                    begin
                        if (stall == 0)
                        begin
                            pop   <= 1'b1;
                            stall = $urandom_range(1, 30);
                        end
                        else
                        begin
                            pop   <= 1'b0;
                            stall = stall - 1;
                        end
                    end
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int sent;
        int burst_left;
        int gap_left;

        rst_n = 1'b0;
        push  = 1'b0;
        pop   = 1'b0;
        key   = '0;

        build_directed();
        n_directed = key_list.size();
        build_random();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Sender: bursts of back-to-back keys with random gaps between them.
        // The gaps land on every phase of the 16-round run.
        sent       = 0;
        burst_left = $urandom_range(1, 12);
        gap_left   = 0;
        while (sent < key_list.size())
        begin
            @(negedge clk);
            if (gap_left > 0)
            begin
                push     <= 1'b0;
                gap_left = gap_left - 1;
            end
            else
            begin
                push <= 1'b1;
                key  <= key_list[sent];
                @(posedge clk);
                while (full)
                    @(posedge clk);
                // transfer taken at this edge
                sent       = sent + 1;
                burst_left = burst_left - 1;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 40);
                end
            end
        end
        @(negedge clk);
        push <= 1'b0;
        key  <= {$urandom, $urandom};

        wait (pending == 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Covered %0d keys (%0d directed, %0d random) and %0d subkey transfers,",
                 keys_in, n_directed, key_list.size() - n_directed, subkeys_out);
        $display("with bursty key pushes and patterned pop stalls; %0d mismatches in %0d cycles",
                 errors, cycle_count);
        if (errors == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
